### rtl/core/msdl_pkg.sv
// Package for the stereo downmix limiter: widths, coefficients, register indexes.
// No dependencies.
`default_nettype none
package msdl_pkg;
  localparam int MaxChannels = 8;
  localparam int SumW = 36;
  localparam logic [23:0] UnityGain = 24'd8388608;
  localparam logic [22:0] CeilingQ23 = 23'd8346665;
  localparam logic [15:0] ReleaseQ24 = 16'd33554;
  localparam logic [15:0] CoefFront = 16'd29491;
  localparam logic [15:0] CoefCenter = 16'd16384;
  localparam logic [15:0] CoefSurround = 16'd8192;
  localparam logic [15:0] CoefLfe = 16'd2621;
  localparam logic [15:0] CoefShared = 16'd5243;
  localparam logic [1:0] RegChannelCount = 2'd0;
  localparam logic [1:0] RegSpeakerMask = 2'd1;
  localparam logic [1:0] RegSampleFormat = 2'd2;
  localparam logic [1:0] FmtPcm16 = 2'd0;
  localparam logic [1:0] FmtPcm24 = 2'd1;
  localparam logic [1:0] FmtPcm32 = 2'd2;

  typedef struct packed {
    logic [15:0] cl;
    logic [15:0] cr;
  } coef_t;

  function automatic coef_t speaker_coef(input logic [5:0] spk);
    coef_t c;
    c = '{cl: CoefShared, cr: CoefShared};
    unique case (spk)
      6'd0: c = '{cl: CoefFront, cr: 16'd0};
      6'd1: c = '{cl: 16'd0, cr: CoefFront};
      6'd2: c = '{cl: CoefCenter, cr: CoefCenter};
      6'd3: c = '{cl: CoefLfe, cr: CoefLfe};
      6'd4, 6'd9, 6'd6, 6'd12, 6'd15: c = '{cl: CoefSurround, cr: 16'd0};
      6'd5, 6'd10, 6'd7, 6'd14, 6'd17: c = '{cl: 16'd0, cr: CoefSurround};
      default: c = '{cl: CoefShared, cr: CoefShared};
    endcase
    return c;
  endfunction
endpackage
`default_nettype wire

### rtl/core/msdl_stream_if.sv
// Valid/ready stream interface carrying a payload of parameterised width.
// Depends on nothing.
`default_nettype none
interface msdl_stream_if #(parameter int W = 32);
  logic valid;
  logic ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/core/msdl_serial_mac.sv
// Bit-serial multiply: signed multiplicand by unsigned multiplier, one bit a cycle.
// Uses msdl_pkg.
`default_nettype none
module msdl_serial_mac
  import msdl_pkg::*;
#(
  parameter int AW = 36,
  parameter int BW = 24
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic signed [AW-1:0] a_i,
  input  wire logic [BW-1:0]     b_i,
  output logic                   done_o,
  output logic signed [AW+BW:0]  prod_o
);
  localparam int CW = $clog2(BW + 1);
  logic [CW-1:0] cnt_q, cnt_d;
  logic busy_q, busy_d, done_q, done_d;
  logic signed [AW+BW:0] acc_q, acc_d, a_q, a_d;
  logic [BW-1:0] b_q, b_d;

  always_comb begin
    cnt_d = cnt_q; busy_d = busy_q; done_d = 1'b0;
    acc_d = acc_q; a_d = a_q; b_d = b_q;
    if (start_i) begin
      busy_d = 1'b1; cnt_d = '0; acc_d = '0;
      a_d = (AW+BW+1)'(a_i); b_d = b_i;
    end else if (busy_q) begin
      if (b_q[0]) acc_d = acc_q + a_q;
      a_d = a_q <<< 1;
      b_d = b_q >> 1;
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CW'(BW - 1)) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0; busy_q <= 1'b0; done_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d; busy_q <= busy_d; done_q <= done_d;
    end
  end
  always_ff @(posedge clk_i) begin
    acc_q <= acc_d; a_q <= a_d; b_q <= b_d;
  end
  assign done_o = done_q;
  assign prod_o = acc_q;
endmodule
`default_nettype wire

### rtl/core/msdl_serial_div.sv
// Restoring divider, one quotient bit a cycle: floor(Ceiling * 2^23 / den).
// Uses msdl_pkg.
`default_nettype none
module msdl_serial_div
  import msdl_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [35:0] den_i,
  output logic             done_o,
  output logic [23:0]      quot_o
);
  localparam int NW = 46;
  logic [5:0] cnt_q, cnt_d;
  logic busy_q, busy_d, done_q, done_d;
  logic [NW-1:0] num_q, num_d;
  logic [36:0] rem_q, rem_d, trial;
  logic [35:0] den_q, den_d;
  logic [23:0] quot_q, quot_d;

  always_comb begin
    cnt_d = cnt_q; busy_d = busy_q; done_d = 1'b0;
    num_d = num_q; rem_d = rem_q; den_d = den_q; quot_d = quot_q;
    trial = {rem_q[35:0], num_q[NW-1]} - {1'b0, den_q};
    if (start_i) begin
      busy_d = 1'b1; cnt_d = '0; rem_d = '0; quot_d = '0;
      num_d = {CeilingQ23, 23'd0}; den_d = den_i;
    end else if (busy_q) begin
      num_d = num_q << 1;
      if (!trial[36]) begin
        rem_d = trial; quot_d = {quot_q[22:0], 1'b1};
      end else begin
        rem_d = {rem_q[35:0], num_q[NW-1]}; quot_d = {quot_q[22:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == 6'(NW - 1)) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0; busy_q <= 1'b0; done_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d; busy_q <= busy_d; done_q <= done_d;
    end
  end
  always_ff @(posedge clk_i) begin
    num_q <= num_d; rem_q <= rem_d; den_q <= den_d; quot_q <= quot_d;
  end
  assign done_o = done_q;
  assign quot_o = quot_q;
endmodule
`default_nettype wire

### rtl/core/multichannel_stereo_downmix_limiter_unit.sv
// Surround-to-stereo downmix with linked peak limiter: one sample per transfer,
// one stereo transfer per frame. A one- or two-channel sample skips the multiplies.
// A matrix sample takes a mask scan, then two bit-serial coefficient multiplies
// (left then right). The frame's last sample adds two serial gain multiplies,
// a serial divide when the peak is above the ceiling, and a wait while the
// previous result is still held.
// Write configuration only while the unit is idle and no result is held.
// Uses msdl_pkg, msdl_stream_if, msdl_serial_mac, msdl_serial_div.
`default_nettype none
module multichannel_stereo_downmix_limiter_unit
  import msdl_pkg::*;
#(
  parameter int MAX_CHANNELS = MaxChannels
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i,
  msdl_stream_if.sink      in_if,
  msdl_stream_if.source    out_if
);
  localparam int PW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam logic [2:0] StIdle = 3'd0, StScan = 3'd1, StMulL = 3'd2,
    StMulR = 3'd3, StDiv = 3'd4, StOutL = 3'd5, StOutR = 3'd6, StHold = 3'd7;

  logic [3:0] cnt_reg_q;
  logic [31:0] mask_q;
  logic [1:0] fmt_q;
  logic [2:0] st_q, st_d;
  logic [PW-1:0] pos_q, pos_d;
  logic signed [SumW-1:0] lsum_q, lsum_d, rsum_q, rsum_d;
  logic [23:0] gain_q, gain_d;
  logic signed [31:0] smp_q, smp_d;
  logic [5:0] bit_q, bit_d, seen_q, seen_d, spk_q, spk_d;
  logic [5:0] ncnt;
  logic [23:0] lout_q, lout_d, rout_q, rout_d;
  logic ovalid_q, ovalid_d, last_q, last_d;
  logic signed [31:0] norm;
  logic mac_start, mac_done, div_start, div_done;
  logic signed [SumW-1:0] mac_a;
  logic [23:0] mac_b, quot;
  logic signed [SumW+24:0] prod;
  logic [SumW-1:0] al, ar, peak;
  logic [23:0] target, inc;
  logic [40:0] incp;
  logic [24:0] gsum;
  logic signed [SumW+24:0] vsh;
  logic [23:0] clamped;
  coef_t cf;
  coef_t cf_next;

  always_comb begin
    ncnt = (cnt_reg_q == 4'd0) ? 6'd1 :
           ({2'b0, cnt_reg_q} > 6'(MAX_CHANNELS)) ? 6'(MAX_CHANNELS) : {2'b0, cnt_reg_q};
    unique case (fmt_q)
      FmtPcm16: norm = {in_if.data[15:0], 16'd0};
      FmtPcm24: norm = {in_if.data[23:0], 8'd0};
      FmtPcm32: norm = in_if.data;
      default:  norm = '0;
    endcase
    cf = speaker_coef(spk_q);
    al = lsum_q[SumW-1] ? SumW'(-lsum_q) : lsum_q;
    ar = rsum_q[SumW-1] ? SumW'(-rsum_q) : rsum_q;
    peak = (al > ar) ? al : ar;
    incp = 41'({1'b0, UnityGain - gain_q} * ReleaseQ24) + 41'h0FFFFFF;
    inc = {7'd0, incp[40:24]};
    vsh = prod >>> 23;
    if (vsh > 61'sd8388607) clamped = 24'h7FFFFF;
    else if (vsh < -61'sd8388608) clamped = 24'h800000;
    else clamped = vsh[23:0];
  end

  always_comb begin
    st_d = st_q; pos_d = pos_q; lsum_d = lsum_q; rsum_d = rsum_q; gain_d = gain_q;
    smp_d = smp_q; bit_d = bit_q; seen_d = seen_q; spk_d = spk_q;
    lout_d = lout_q; rout_d = rout_q; ovalid_d = ovalid_q; last_d = last_q;
    mac_start = 1'b0; div_start = 1'b0;
    mac_a = '0; mac_b = '0; target = UnityGain; gsum = '0;
    cf_next = cf;
    if (out_if.valid && out_if.ready) ovalid_d = 1'b0;
    unique case (st_q)
      StIdle: if (in_if.valid) begin
        smp_d = norm;
        last_d = ({{(6-PW){1'b0}}, pos_q} + 6'd1) >= ncnt;
        if (ncnt == 6'd1) begin
          lsum_d = lsum_q + SumW'(norm >>> 8); rsum_d = rsum_q + SumW'(norm >>> 8);
          st_d = StHold;
        end else if (ncnt == 6'd2) begin
          if (pos_q == '0) lsum_d = lsum_q + SumW'(norm >>> 8);
          else rsum_d = rsum_q + SumW'(norm >>> 8);
          st_d = StHold;
        end else begin
          bit_d = '0; seen_d = '0; spk_d = 6'd63; st_d = StScan;
        end
      end
      StScan: begin
        if (mask_q[bit_q[4:0]]) begin
          if (seen_q == {{(6-PW){1'b0}}, pos_q}) begin
            spk_d = bit_q; st_d = StMulL; mac_start = 1'b1;
          end
          seen_d = seen_q + 1'b1;
        end
        if (st_d == StScan) begin
          if (bit_q == 6'd31) begin st_d = StMulL; mac_start = 1'b1; end
          bit_d = bit_q + 1'b1;
        end
        cf_next = speaker_coef(spk_d);
        mac_a = SumW'(smp_q);
        mac_b = {8'd0, cf_next.cl};
      end
      StMulL: begin
        mac_a = SumW'(smp_q); mac_b = {8'd0, cf.cr};
        if (mac_done) begin
          lsum_d = lsum_q + SumW'(prod >>> 24); mac_start = 1'b1; st_d = StMulR;
        end
      end
      StMulR: if (mac_done) begin
        rsum_d = rsum_q + SumW'(prod >>> 24); st_d = StHold;
      end
      StHold: begin
        if (!last_q) begin
          pos_d = pos_q + 1'b1; st_d = StIdle;
        end else if (!ovalid_d) begin
          pos_d = '0;
          if (peak > SumW'(CeilingQ23)) begin div_start = 1'b1; st_d = StDiv; end
          else begin
            gsum = {1'b0, gain_q} + {1'b0, inc};
            gain_d = (gsum > {1'b0, UnityGain}) ? UnityGain : gsum[23:0];
            st_d = StOutL; mac_start = 1'b1;
            mac_a = lsum_q; mac_b = gain_d;
          end
        end
      end
      StDiv: if (div_done) begin
        target = quot;
        if (target < gain_q) gain_d = target;
        else begin
          gsum = {1'b0, gain_q} + {1'b0, inc};
          gain_d = (gsum > {1'b0, UnityGain}) ? UnityGain : gsum[23:0];
        end
        st_d = StOutL; mac_start = 1'b1; mac_a = lsum_q; mac_b = gain_d;
      end
      StOutL: begin
        mac_a = rsum_q; mac_b = gain_q;
        if (mac_done) begin lout_d = clamped; mac_start = 1'b1; st_d = StOutR; end
      end
      StOutR: if (mac_done) begin
        rout_d = clamped; ovalid_d = 1'b1; lsum_d = '0; rsum_d = '0; st_d = StIdle;
      end
      default: st_d = StIdle;
    endcase
  end

  msdl_serial_mac #(.AW(SumW), .BW(24)) u_mac (
    .clk_i, .rst_ni, .start_i(mac_start), .a_i(mac_a), .b_i(mac_b),
    .done_o(mac_done), .prod_o(prod));
  msdl_serial_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .den_i(peak), .done_o(div_done), .quot_o(quot));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_reg_q <= 4'd2; mask_q <= 32'd1599; fmt_q <= FmtPcm16;
      st_q <= StIdle; pos_q <= '0; lsum_q <= '0; rsum_q <= '0; gain_q <= UnityGain;
      ovalid_q <= 1'b0; last_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          RegChannelCount: cnt_reg_q <= cfg_data_i[3:0];
          RegSpeakerMask:  mask_q <= cfg_data_i;
          RegSampleFormat: fmt_q <= cfg_data_i[1:0];
          default: ;
        endcase
      end
      st_q <= st_d; pos_q <= pos_d; lsum_q <= lsum_d; rsum_q <= rsum_d;
      gain_q <= gain_d; ovalid_q <= ovalid_d; last_q <= last_d;
    end
  end
  always_ff @(posedge clk_i) begin
    smp_q <= smp_d; bit_q <= bit_d; seen_q <= seen_d; spk_q <= spk_d;
    lout_q <= lout_d; rout_q <= rout_d;
  end

  assign in_if.ready = (st_q == StIdle);
  assign out_if.valid = ovalid_q;
  assign out_if.data = {lout_q, rout_q};

  a_gain_le_unity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gain_q <= UnityGain) else $error("gain above unity");
  a_out_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ovalid_q) |-> st_q == StIdle) else $error("result raised outside idle");
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {{(6-PW){1'b0}}, pos_q} < 6'(MAX_CHANNELS)) else $error("position out of range");
endmodule
`default_nettype wire
